// ----- rtl/ppsu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppsu_pkg
// Widths, codes and shared types of the piecewise polynomial sweep unit.
// ----------------------------------------------------------------------------
package ppsu_pkg;

  // Field widths
  localparam int unsigned COEF_W    = 32;  // Q16.16 coefficient, start, step, probe
  localparam int unsigned COL_W     = 6;
  localparam int unsigned SEG_W     = 4;
  localparam int unsigned TERM_W    = 2;
  localparam int unsigned TOL_W     = 31;
  localparam int unsigned ACC_W     = 48;  // Q32.16 accumulator
  localparam int unsigned X_W       = 38;  // start + column * step, exact
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned PROD_W    = ACC_W + X_W;
  localparam int unsigned CFG_IDX_W = 2;

  // Split of acc * x into four partial products
  localparam int unsigned AL_W = ACC_W / 2;
  localparam int unsigned XL_W = (X_W + 1) / 2;
  localparam int unsigned HH_W = (ACC_W - AL_W) + (X_W - XL_W);
  localparam int unsigned HL_W = (ACC_W - AL_W) + XL_W + 1;
  localparam int unsigned LH_W = AL_W + 1 + (X_W - XL_W);
  localparam int unsigned LL_W = AL_W + XL_W;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [COEF_W-1:0] X_STEP_RST = 32'h0001_0000;  // 1.0

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_START   = 2'd0,
    CFG_X_STEP    = 2'd1,
    CFG_TOLERANCE = 2'd2
  } cfg_index_e;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_e;

  typedef struct packed {
    logic signed [HH_W-1:0] hh;
    logic signed [HL_W-1:0] hl;
    logic signed [LH_W-1:0] lh;
    logic        [LL_W-1:0] ll;
  } pp_t;

endpackage
`default_nettype wire

// ----- rtl/ppsu_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppsu_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module ppsu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire [AW-1:0]     waddr_i,
  input  wire [WIDTH-1:0]  wdata_i,
  input  wire              re_i,
  input  wire [AW-1:0]     raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/piecewise_polynomial_sweep_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_polynomial_sweep_unit
// Piecewise polynomial evaluator over a column sweep, Horner's rule, Q16.16.
//
// A load transfer (kind 0) writes one coefficient, segment/term addressed;
// loads with segment >= SEGMENTS or term >= TERMS are dropped, and no load
// gives a result. An evaluate
// transfer (kind 1) forms x = x_start + column * x_step, picks segment
// column / STEPS_PER_SEGMENT (segment 0 once past the last segment), runs
// Horner over TERMS coefficients and returns the value saturated to Q32.16
// together with near_probe = |value - probe_level| < tolerance.
// Throughput is one transfer per clock on the input channel, loads and
// evaluates freely mixed, unless every stage is full and the output stalls.
// The pipe has 3*TERMS stages (12 with four terms): one for the
// coefficient read, one for forming x, three per Horner step (partial
// products, product sum, rescale/saturate/add) and one for the probe
// compare. The first stage loads at the evaluate transfer itself, and the
// result is offered once the item has passed through every stage.
// All stages carry a valid bit and advance independently, so
// bubbles are squeezed out and the input keeps taking items while a result
// waits at the output, as long as some stage is still empty. The
// coefficient table is one RAM per term; entries
// come up undefined and must be loaded before they are used, and there is
// no clearing pass. Configuration registers should only be written while
// the pipe is empty.
// ----------------------------------------------------------------------------
module piecewise_polynomial_sweep_unit
  import ppsu_pkg::*;
#(
  parameter int unsigned TERMS             = 4,
  parameter int unsigned SEGMENTS          = 16,
  parameter int unsigned STEPS_PER_SEGMENT = 5
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // configuration write channel
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [COEF_W-1:0]           cfg_wdata_i,
  // item input channel
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire                         kind_i,
  input  wire  [SEG_W-1:0]            segment_i,
  input  wire  [TERM_W-1:0]           term_i,
  input  wire  signed [COEF_W-1:0]    coefficient_i,
  input  wire  [COL_W-1:0]            column_i,
  input  wire  signed [COEF_W-1:0]    probe_level_i,
  // result output channel
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [COL_W-1:0]            out_column_o,
  output logic signed [ACC_W-1:0]     value_o,
  output logic                        near_probe_o
);

  localparam int unsigned SEG_AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned NSTG   = 3 * TERMS;
  localparam int unsigned LAST   = NSTG - 1;

  // column / STEPS_PER_SEGMENT by reciprocal multiply, exact for COL_W bits
  localparam int unsigned DIV_SH = COL_W + $clog2(STEPS_PER_SEGMENT);
  localparam int unsigned DIV_MW = COL_W + 2;
  localparam int unsigned DIV_PW = COL_W + DIV_MW;
  localparam logic [DIV_MW-1:0] DIV_M =
    DIV_MW'(((1 << DIV_SH) + STEPS_PER_SEGMENT - 1) / STEPS_PER_SEGMENT);

  typedef struct packed {
    logic        [COL_W-1:0]            column;
    logic signed [COEF_W-1:0]           probe;
    logic signed [X_W-1:0]              x;
    logic        [TERMS-1:0][COEF_W-1:0] coef;
  } carry_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0] x_start_q;
  logic signed [COEF_W-1:0] x_step_q;
  logic        [TOL_W-1:0]  tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_start_q <= '0;
      x_step_q  <= X_STEP_RST;
      tol_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_X_START:   x_start_q <= cfg_wdata_i;
        CFG_X_STEP:    x_step_q  <= cfg_wdata_i;
        CFG_TOLERANCE: tol_q     <= cfg_wdata_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage loads when it is empty or anything
  // downstream of it can move.
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] v_d;
  logic [NSTG-1:0] en;
  logic            ev_in;
  logic            ev_acc;
  logic            ld_acc;

  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = out_ready_i || !(&v_q[LAST:k]);
  end

  assign in_ready_o = en[0];
  assign ev_in      = in_valid_i && (kind_i == KIND_EVAL);
  assign ev_acc     = ev_in && en[0];
  assign ld_acc     = in_valid_i && en[0] && (kind_i == KIND_LOAD);

  assign v_d = (en & {v_q[NSTG-2:0], ev_in}) | (~en & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: coefficient read, one RAM per term, all read in the transfer cycle
  // --------------------------------------------------------------------------
  logic [DIV_PW-1:0]             div_prod;
  logic [COL_W-1:0]              seg_quo;
  logic [SEG_AW-1:0]             rd_seg;
  logic                          seg_ok;
  logic [TERMS-1:0][COEF_W-1:0]  s0_coef;
  logic [COL_W-1:0]              s0_col_q;
  logic signed [COEF_W-1:0]      s0_probe_q;

  assign div_prod = DIV_PW'(column_i) * DIV_PW'(DIV_M);
  assign seg_quo  = COL_W'(div_prod >> DIV_SH);
  // past the last segment: wrap to segment 0
  assign rd_seg   = (32'(seg_quo) < SEGMENTS) ? SEG_AW'(seg_quo) : '0;
  assign seg_ok   = 32'(segment_i) < SEGMENTS;

  for (genvar t = 0; t < TERMS; t++) begin : g_ram
    ppsu_ram #(
      .WIDTH (COEF_W),
      .DEPTH (SEGMENTS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ld_acc && seg_ok && (32'(term_i) == t)),
      .waddr_i (SEG_AW'(segment_i)),
      .wdata_i (coefficient_i),
      .re_i    (ev_acc),
      .raddr_i (rd_seg),
      .rdata_o (s0_coef[t])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_col_q   <= column_i;
      s0_probe_q <= probe_level_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: x = start + column * step; acc starts at the top coefficient.
  // a_car_q/a_acc_q[j] hold the item after j Horner steps.
  // --------------------------------------------------------------------------
  logic signed [X_W:0]       s0_x_full;
  carry_t                    a_car_q [TERMS];
  logic signed [ACC_W-1:0]   a_acc_q [TERMS];

  assign s0_x_full = (X_W+1)'($signed({1'b0, s0_col_q})) * (X_W+1)'(x_step_q)
                   + (X_W+1)'(x_start_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      a_car_q[0].column <= s0_col_q;
      a_car_q[0].probe  <= s0_probe_q;
      a_car_q[0].x      <= s0_x_full[X_W-1:0];
      a_car_q[0].coef   <= s0_coef;
      a_acc_q[0]        <= ACC_W'($signed(s0_coef[TERMS-1]));
    end
  end

  // --------------------------------------------------------------------------
  // Horner steps, three stages each
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < TERMS - 1; j++) begin : g_step
    localparam int unsigned KP = 2 + 3 * j;
    localparam int unsigned KS = KP + 1;
    localparam int unsigned KA = KP + 2;
    localparam int unsigned CI = TERMS - 2 - j;

    logic signed [ACC_W-AL_W-1:0] a_hi;
    logic        [AL_W-1:0]       a_lo;
    logic signed [X_W-XL_W-1:0]   x_hi;
    logic        [XL_W-1:0]       x_lo;
    carry_t                       p_car_q;
    pp_t                          pp_q;
    carry_t                       s_car_q;
    logic signed [PROD_W-1:0]     prod_d;
    logic signed [PROD_W-1:0]     prod_q;
    logic [PROD_W-ACC_W-FRAC_W:0] top;
    logic signed [ACC_W-1:0]      mul_sat;
    logic signed [ACC_W:0]        sum;
    logic signed [ACC_W-1:0]      acc_d;

    assign a_hi = a_acc_q[j][ACC_W-1:AL_W];
    assign a_lo = a_acc_q[j][AL_W-1:0];
    assign x_hi = a_car_q[j].x[X_W-1:XL_W];
    assign x_lo = a_car_q[j].x[XL_W-1:0];

    // partial products
    always_ff @(posedge clk_i) begin
      if (en[KP]) begin
        p_car_q <= a_car_q[j];
        pp_q.hh <= a_hi * x_hi;
        pp_q.hl <= a_hi * $signed({1'b0, x_lo});
        pp_q.lh <= $signed({1'b0, a_lo}) * x_hi;
        pp_q.ll <= a_lo * x_lo;
      end
    end

    // full product, Q54.32
    assign prod_d = (PROD_W'($signed(pp_q.hh)) <<< (AL_W + XL_W))
                  + (PROD_W'($signed(pp_q.hl)) <<< AL_W)
                  + (PROD_W'($signed(pp_q.lh)) <<< XL_W)
                  + PROD_W'(pp_q.ll);

    always_ff @(posedge clk_i) begin
      if (en[KS]) begin
        s_car_q <= p_car_q;
        prod_q  <= prod_d;
      end
    end

    // drop 16 fraction bits (floor), saturate, add coefficient, saturate
    assign top     = prod_q[PROD_W-1:ACC_W+FRAC_W-1];
    assign mul_sat = ((&top) || !(|top)) ? prod_q[ACC_W+FRAC_W-1:FRAC_W]
                   : (prod_q[PROD_W-1] ? ACC_MIN : ACC_MAX);
    assign sum     = (ACC_W+1)'(mul_sat) + (ACC_W+1)'($signed(s_car_q.coef[CI]));
    assign acc_d   = (sum[ACC_W] == sum[ACC_W-1]) ? sum[ACC_W-1:0]
                   : (sum[ACC_W] ? ACC_MIN : ACC_MAX);

    always_ff @(posedge clk_i) begin
      if (en[KA]) begin
        a_car_q[j+1] <= s_car_q;
        a_acc_q[j+1] <= acc_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: probe window compare, -tol < diff < tol
  // --------------------------------------------------------------------------
  logic signed [ACC_W+1:0] diff;
  logic signed [ACC_W+1:0] tol_s;
  logic                    near;
  logic [COL_W-1:0]        out_col_q;
  logic signed [ACC_W-1:0] value_q;
  logic                    near_q;

  assign diff  = (ACC_W+2)'(a_acc_q[TERMS-1])
               - (ACC_W+2)'($signed(a_car_q[TERMS-1].probe));
  assign tol_s = (ACC_W+2)'({1'b0, tol_q});
  assign near  = (diff < tol_s) && (diff > -tol_s);

  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      out_col_q <= a_car_q[TERMS-1].column;
      value_q   <= a_acc_q[TERMS-1];
      near_q    <= near;
    end
  end

  assign out_valid_o  = v_q[LAST];
  assign out_column_o = out_col_q;
  assign value_o      = value_q;
  assign near_probe_o = near_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // items in flight change only by evaluate transfers in and results out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(v_q) + int'($past(out_valid_o && out_ready_i))
       == $past($countones(v_q)) + int'($past(ev_acc))))
    else $error("pipeline occupancy lost or duplicated an item");

  // a zero tolerance window can never report a near hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (tol_q == '0)) |-> !near_probe_o)
    else $error("near_probe set with zero tolerance");

endmodule
`default_nettype wire

// ----- test/ppsu_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppsu_checker
// Watches the configuration, item and result channels of the sweep unit,
// predicts every evaluate transfer with its own Horner evaluator and compares
// each result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ppsu_checker
  import ppsu_pkg::*;
#(
  parameter int unsigned TERMS             = 4,
  parameter int unsigned SEGMENTS          = 16,
  parameter int unsigned STEPS_PER_SEGMENT = 5
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_valid_i,
  input  wire                       cfg_ready_i,
  input  wire  [CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [COEF_W-1:0]         cfg_wdata_i,
  input  wire                       in_valid_i,
  input  wire                       in_ready_i,
  input  wire                       kind_i,
  input  wire  [SEG_W-1:0]          segment_i,
  input  wire  [TERM_W-1:0]         term_i,
  input  wire  signed [COEF_W-1:0]  coefficient_i,
  input  wire  [COL_W-1:0]          column_i,
  input  wire  signed [COEF_W-1:0]  probe_level_i,
  input  wire                       out_valid_i,
  input  wire                       out_ready_i,
  input  wire  [COL_W-1:0]          out_column_i,
  input  wire  signed [ACC_W-1:0]   value_i,
  input  wire                       near_probe_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic [COL_W-1:0]        column;
    logic signed [ACC_W-1:0] value;
    logic                    near_probe;
  } sweep_result_t;

  logic signed [COEF_W-1:0] x_start;
  logic signed [COEF_W-1:0] x_step;
  logic [TOL_W-1:0]         tolerance;
  logic signed [COEF_W-1:0] coef_table [SEGMENTS][TERMS];
  sweep_result_t            awaited_results [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [PROD_W-1:0] v);
    if (v > $signed(ACC_MAX)) begin
      return ACC_MAX;
    end else if (v < $signed(ACC_MIN)) begin
      return ACC_MIN;
    end
    return v[ACC_W-1:0];
  endfunction

  // x = start + column * step, exact; floor rescale and 48-bit clamp per step
  function automatic sweep_result_t horner_eval(input logic [COL_W-1:0] col,
                                                input logic signed [COEF_W-1:0] probe);
    sweep_result_t            r;
    int unsigned              seg;
    int                       t;
    logic signed [X_W-1:0]    x;
    logic signed [ACC_W-1:0]  acc;
    logic signed [PROD_W-1:0] wide;
    logic signed [PROD_W-1:0] tol_w;
    seg = col / STEPS_PER_SEGMENT;
    if (seg >= SEGMENTS) begin
      seg = 0;
    end
    x   = X_W'(x_start) + X_W'($signed({1'b0, col})) * X_W'(x_step);
    acc = ACC_W'(coef_table[seg][TERMS-1]);
    for (t = TERMS - 2; t >= 0; t--) begin
      wide = PROD_W'(acc) * PROD_W'(x);
      acc  = clamp_acc(wide >>> FRAC_W);
      wide = PROD_W'(acc) + PROD_W'(coef_table[seg][t]);
      acc  = clamp_acc(wide);
    end
    wide = PROD_W'(acc) - PROD_W'(probe);
    if (wide < 0) begin
      wide = -wide;
    end
    tol_w = PROD_W'({1'b0, tolerance});
    r.column     = col;
    r.value      = acc;
    r.near_probe = (wide < tol_w);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sweep_result_t want;
    if (!rst_ni) begin
      x_start   = '0;
      x_step    = X_STEP_RST;
      tolerance = '0;
      awaited_results.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result for column %0d with nothing awaited",
                                    out_column_i));
        end else begin
          want = awaited_results.pop_front();
          if (out_column_i !== want.column) begin
            report_mismatch($sformatf("out_column expected %0d, got %0d",
                                      want.column, out_column_i));
          end
          if (value_i !== want.value) begin
            report_mismatch($sformatf("value (column %0d) expected %h, got %h",
                                      want.column, want.value, value_i));
          end
          if (near_probe_i !== want.near_probe) begin
            report_mismatch($sformatf("near_probe (column %0d) expected %b, got %b",
                                      want.column, want.near_probe, near_probe_i));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_X_START:   x_start   = cfg_wdata_i;
          CFG_X_STEP:    x_step    = cfg_wdata_i;
          CFG_TOLERANCE: tolerance = cfg_wdata_i[TOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (kind_i == KIND_LOAD) begin
          if (segment_i < SEGMENTS && term_i < TERMS) begin
            coef_table[segment_i][term_i] = coefficient_i;
          end
        end else begin
          awaited_results.push_back(horner_eval(column_i, probe_level_i));
        end
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the piecewise polynomial sweep unit: a directed
// run over extreme coefficients and saturation, then eight configuration
// phases of random load/evaluate traffic under varying idling, checked by
// ppsu_checker.
// ----------------------------------------------------------------------------
module tb;
  import ppsu_pkg::*;

  localparam int unsigned TERMS             = 4;
  localparam int unsigned SEGMENTS          = 16;
  localparam int unsigned STEPS_PER_SEGMENT = 5;
  localparam int unsigned COLUMNS           = 64;
  localparam int          PHASES            = 8;
  localparam int          ITEMS_PER_PHASE   = 190;
  localparam int          DRAIN_CYCLES      = 24;    // pipe is 12 deep, plus margin
  localparam int          MAX_GAP           = 40;    // cap on one sender idle stretch
  localparam int          STALL_LIMIT       = 2000;  // cycles without any transfer

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [COEF_W-1:0]         cfg_wdata = '0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      kind = KIND_LOAD;
  logic [SEG_W-1:0]          segment = '0;
  logic [TERM_W-1:0]         term = '0;
  logic signed [COEF_W-1:0]  coefficient = '0;
  logic [COL_W-1:0]          column = '0;
  logic signed [COEF_W-1:0]  probe_level = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [COL_W-1:0]          out_column;
  logic signed [ACC_W-1:0]   value;
  logic                      near_probe;

  int                        fail_count;
  int                        pending;

  // Stimulus-side record of what has been sent: which table entries hold a
  // value (unwritten entries must never be read) and the constant term of
  // each segment, used to aim probes when x is held at zero.
  logic [TERMS-1:0]          loaded [SEGMENTS];
  logic signed [COEF_W-1:0]  c0_sent [SEGMENTS];

  int                        send_idle_pct = 0;
  int                        stall_pct = 0;
  int                        quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  piecewise_polynomial_sweep_unit #(
    .TERMS             (TERMS),
    .SEGMENTS          (SEGMENTS),
    .STEPS_PER_SEGMENT (STEPS_PER_SEGMENT)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .kind_i        (kind),
    .segment_i     (segment),
    .term_i        (term),
    .coefficient_i (coefficient),
    .column_i      (column),
    .probe_level_i (probe_level),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_column_o  (out_column),
    .value_o       (value),
    .near_probe_o  (near_probe)
  );

  ppsu_checker #(
    .TERMS             (TERMS),
    .SEGMENTS          (SEGMENTS),
    .STEPS_PER_SEGMENT (STEPS_PER_SEGMENT)
  ) u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .kind_i        (kind),
    .segment_i     (segment),
    .term_i        (term),
    .coefficient_i (coefficient),
    .column_i      (column),
    .probe_level_i (probe_level),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_column_i  (out_column),
    .value_i       (value),
    .near_probe_i  (near_probe),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Result side: ready drops at random, per the current stall percentage.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: any cycle with a transfer on some channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // 0: none, 1: sender idle 75 %, 2: receiver stalls 75 %, 3: both 10 %
  task automatic set_idling(input int mode);
    case (mode)
      1:       begin send_idle_pct = 75; stall_pct <= 0;  end
      2:       begin send_idle_pct = 0;  stall_pct <= 75; end
      3:       begin send_idle_pct = 10; stall_pct <= 10; end
      default: begin send_idle_pct = 0;  stall_pct <= 0;  end
    endcase
  endtask

  // One item transfer. Valid is only lowered when an idle gap precedes the
  // item, so back-to-back items never see valid dropped and raised in a step.
  task automatic send_item(input kind_e k, input logic [SEG_W-1:0] sg,
                           input logic [TERM_W-1:0] tm, input logic signed [COEF_W-1:0] cf,
                           input logic [COL_W-1:0] col, input logic signed [COEF_W-1:0] pl);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    segment     <= sg;
    term        <= tm;
    coefficient <= cf;
    column      <= col;
    probe_level <= pl;
    do @(posedge clk_i); while (!in_ready);
    if (k == KIND_LOAD && sg < SEGMENTS && tm < TERMS) begin
      loaded[sg][tm] = 1'b1;
      if (tm == 0) begin
        c0_sent[sg] = cf;
      end
    end
  endtask

  // Register write; valid is left high so that consecutive writes run on.
  task automatic write_reg(input cfg_index_e idx, input logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Let the pipe empty: all results in, then cover loads still in flight.
  task automatic settle_pipe();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [COEF_W-1:0] small_value(input int unsigned half);
    return $signed($urandom_range(0, 2 * half)) - $signed(half);
  endfunction

  initial begin
    int                       p;
    int                       n;
    int unsigned              sg;
    logic [COL_W-1:0]         col;
    logic signed [COEF_W-1:0] cf;
    logic signed [COEF_W-1:0] pl;
    logic [COEF_W-1:0]        start_v;
    logic [COEF_W-1:0]        step_v;
    logic [COEF_W-1:0]        tol_v;
    bit                       x_zero;
    bit                       x_small;

    for (n = 0; n < SEGMENTS; n++) begin
      loaded[n]  = '0;
      c0_sent[n] = '0;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed run, reset configuration (x = column, tolerance 0) ----
    set_idling(3);
    // segment 0: extreme coefficients, evaluated at x = 0, 1 and 4
    send_item(KIND_LOAD, 0, 3, 32'sh8000_0000, 63, 32'sh7FFF_FFFF);
    send_item(KIND_LOAD, 0, 2, 32'sh7FFF_FFFF, 0, 32'sh8000_0000);
    send_item(KIND_LOAD, 0, 1, 32'sh0000_0000, 0, 32'sh0000_0000);
    send_item(KIND_LOAD, 0, 0, 32'shFFFF_FFFF, 0, 32'sh0000_0000);
    send_item(KIND_EVAL, 15, 3, 32'shFFFF_FFFF, 0, 32'sh8000_0000);
    send_item(KIND_EVAL, 0, 0, 32'sh0000_0000, 1, 32'sh7FFF_FFFF);
    send_item(KIND_EVAL, 0, 0, 32'sh0000_0000, 4, 32'sh0000_0000);
    // segment 11: leading minimum, drives the value into negative saturation
    send_item(KIND_LOAD, 11, 3, 32'sh8000_0000, 0, 32'sh0000_0000);
    send_item(KIND_LOAD, 11, 2, 32'sh0000_0000, 0, 32'sh0000_0000);
    send_item(KIND_LOAD, 11, 1, 32'sh0000_0000, 0, 32'sh0000_0000);
    send_item(KIND_LOAD, 11, 0, 32'sh0000_0000, 0, 32'sh0000_0000);
    send_item(KIND_EVAL, 0, 0, 32'sh0000_0000, 57, 32'sh8000_0000);
    // segment 12: all maximum, positive saturation on the last columns
    send_item(KIND_LOAD, 12, 3, 32'sh7FFF_FFFF, 0, 32'sh0000_0000);
    send_item(KIND_LOAD, 12, 2, 32'sh7FFF_FFFF, 0, 32'sh0000_0000);
    send_item(KIND_LOAD, 12, 1, 32'sh7FFF_FFFF, 0, 32'sh0000_0000);
    send_item(KIND_LOAD, 12, 0, 32'sh7FFF_FFFF, 0, 32'sh0000_0000);
    send_item(KIND_EVAL, 0, 0, 32'sh0000_0000, 63, 32'sh7FFF_FFFF);
    send_item(KIND_EVAL, 0, 0, 32'sh0000_0000, 60, 32'sh0000_0000);
    // segment 2: x + 0.5, an exact mid-range value
    send_item(KIND_LOAD, 2, 3, 32'sh0000_0000, 0, 32'sh0000_0000);
    send_item(KIND_LOAD, 2, 2, 32'sh0000_0000, 0, 32'sh0000_0000);
    send_item(KIND_LOAD, 2, 1, 32'sh0001_0000, 0, 32'sh0000_0000);
    send_item(KIND_LOAD, 2, 0, 32'sh0000_8000, 0, 32'sh0000_0000);
    send_item(KIND_EVAL, 0, 0, 32'sh0000_0000, 14, 32'sh000E_8000);
    // a segment that no column reaches still takes a write
    send_item(KIND_LOAD, 15, 3, 32'sh1234_5678, 0, 32'sh0000_0000);
    settle_pipe();

    // ---- random phases: new configuration and idling pattern each ----
    for (p = 0; p < PHASES; p++) begin
      x_zero  = 1'b0;
      x_small = 1'b0;
      case (p)
        0, 4: begin  // x held at zero: value is the constant term, probes aimed at it
          start_v = '0;
          step_v  = '0;
          tol_v   = $urandom_range(0, 4096);
          x_zero  = 1'b1;
        end
        1: begin
          start_v = 32'h8000_0000;
          step_v  = 32'h7FFF_FFFF;
          tol_v   = 32'h7FFF_FFFF;
        end
        2: begin
          start_v = 32'h7FFF_FFFF;
          step_v  = 32'h8000_0000;
          tol_v   = '0;
        end
        5: begin
          start_v = $urandom;
          step_v  = $urandom;
          tol_v   = $urandom;
        end
        7: begin
          start_v = '0;
          step_v  = X_STEP_RST;
          tol_v   = $urandom_range(0, 1 << 24);
        end
        default: begin  // small x, values mostly clear of saturation
          start_v = small_value(1 << 18);
          step_v  = small_value(1 << 14);
          tol_v   = $urandom_range(0, 1 << 20);
          x_small = 1'b1;
        end
      endcase
      write_reg(CFG_X_START, start_v);
      write_reg(CFG_X_STEP, step_v);
      write_reg(CFG_TOLERANCE, tol_v);
      cfg_valid <= 1'b0;
      set_idling(p % 4);

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        col = COL_W'($urandom_range(0, COLUMNS - 1));
        sg  = col / STEPS_PER_SEGMENT;
        if (sg >= SEGMENTS) begin
          sg = 0;
        end
        if (&loaded[sg] && $urandom_range(99) < 60) begin
          if (x_zero) begin
            pl = c0_sent[sg] + small_value(8192);
          end else if (x_small || $urandom_range(1)) begin
            pl = small_value(1 << 20);
          end else begin
            pl = $urandom;
          end
          send_item(KIND_EVAL, SEG_W'($urandom), TERM_W'($urandom), $urandom, col, pl);
        end else begin
          cf = ($urandom_range(3) == 0) ? $signed($urandom) : small_value(1 << 17);
          // fill the segment this column needs before evaluating it
          if (!(&loaded[sg])) begin
            send_item(KIND_LOAD, SEG_W'(sg), TERM_W'($urandom), cf, COL_W'($urandom),
                      $urandom);
          end else begin
            send_item(KIND_LOAD, SEG_W'($urandom), TERM_W'($urandom), cf,
                      COL_W'($urandom), $urandom);
          end
        end
      end
      settle_pipe();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ppsu_pkg.sv
rtl/ppsu_ram.sv
rtl/piecewise_polynomial_sweep_unit.sv
test/ppsu_checker.sv
test/tb.sv
